>>> rtl/mbru_pkg.sv
// Shared constants and types for the MSB-first bit reader with byte unstuffing.
package mbru_pkg;

    // Default buffer depth in bytes
    localparam int BUFFER_BYTES_DEF = 64;

    // Byte banks; a read window spans five consecutive bytes drawn from these banks
    localparam int BANKS = 8;

    // Widest read in bits
    localparam logic [5:0] MAX_BITS = 6'd32;

    // Marker byte that arms unstuffing
    localparam logic [7:0] MARKER_BYTE = 8'hFF;

    // Word function codes
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // Window of bank outputs handed to the extractor
    typedef logic [BANKS-1:0][7:0] window_t;

endpackage

>>> rtl/mbru_bank.sv
// One byte bank of the buffer: single write port, registered write-first read port.
module mbru_bank #(
    parameter int ROW_W = 3
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [ROW_W-1:0] wr_addr,
    input  logic [7:0]       wr_data,
    input  logic [ROW_W-1:0] rd_addr,
    output logic [7:0]       rd_data
);

    localparam int ROWS = 1 << ROW_W;

    logic [7:0] mem [ROWS];
    logic [7:0] rd_data_reg;

    // Write, and read with forwarding of a same-cycle write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/mbru_extract.sv
// Bit extractor: picks up to 32 bits, first bit most significant, from the byte window.
module mbru_extract (
    input  mbru_pkg::window_t bank_q,
    input  logic [2:0]        rd_lo,
    input  logic [2:0]        bit_pos,
    input  logic [5:0]        count,
    output logic [31:0]       value
);

    logic [39:0] win;
    logic [39:0] shifted;
    logic [31:0] top;

    // Rotate bank outputs so byte 0 is the one holding the next unread bit
    always_comb begin
        win = '0;
        for (int j = 0; j < 5; j++) begin
            win[39 - 8*j -: 8] = bank_q[3'(rd_lo + 3'(j))];
        end
    end

    // Drop consumed bits, then right-align the requested count
    assign shifted = win << bit_pos;
    assign top     = shifted[39:8];
    assign value   = (count == 6'd0) ? 32'd0 : (top >> (6'd32 - count));

endmodule

>>> rtl/msb_first_bit_reader_unstuff.sv
// Results pass from the input word register to the result word register. Throughput:
// one word per cycle, push or read, while results are taken; the eight byte banks are
// re-read every cycle at the next read position, so the 40-bit window is always ready.
// Reset (aresetn low, synchronous): pointers, counts, flags and handshakes clear;
// buffer contents stay undefined and need no clearing pass.
module msb_first_bit_reader_unstuff #(
    parameter int BUFFER_BYTES = mbru_pkg::BUFFER_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    // Input words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [7:0]  s_data_byte,
    input  logic [5:0]  s_bit_count,
    input  logic        s_peek,
    // Result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_bits_value,
    output logic [1:0]  m_status,
    output logic [9:0]  m_available_bits,
    output logic [2:0]  m_bit_offset
);

    localparam int ROW_W = ($clog2((BUFFER_BYTES + 7) / 8) < 1) ? 1
                           : $clog2((BUFFER_BYTES + 7) / 8);
    localparam int PW    = ROW_W + 3;
    localparam int HW    = $clog2(BUFFER_BYTES + 1);
    localparam int AW    = HW + 3;

    // State
    logic           unstuff_reg;
    logic           in_valid_reg;
    logic           in_func_reg;
    logic [7:0]     in_data_reg;
    logic [5:0]     in_count_reg;
    logic           in_peek_reg;
    logic [PW-1:0]  rd_pos_reg, rd_pos_next;
    logic [PW-1:0]  wr_pos_reg, wr_pos_next;
    logic [HW-1:0]  held_reg, held_next;
    logic [2:0]     bit_pos_reg, bit_pos_next;
    logic           last_ff_reg, last_ff_next;
    logic           m_valid_reg;
    logic [31:0]    m_value_reg;
    mbru_pkg::status_t m_status_reg;
    logic [9:0]     m_avail_reg;
    logic [2:0]     m_offset_reg;

    // Datapath
    logic              fire;
    logic              push_wr;
    logic [5:0]        count_sat;
    logic [AW-1:0]     avail_now;
    logic [AW-1:0]     avail_next;
    logic [5:0]        total;
    logic [2:0]        advance;
    logic [31:0]       extract_value;
    logic [31:0]       value_next;
    mbru_pkg::status_t status_next;
    mbru_pkg::window_t bank_q;
    logic [PW-1:0]     rd_addr_base;

    assign fire    = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    // Bits still unread before this word
    assign avail_now = {held_reg, 3'b000} - AW'(bit_pos_reg);
    assign count_sat = (in_count_reg > mbru_pkg::MAX_BITS) ? mbru_pkg::MAX_BITS
                       : in_count_reg;
    assign total     = 6'(bit_pos_reg) + count_sat;
    assign advance   = total[5:3];

    mbru_extract u_extract (
        .bank_q  (bank_q),
        .rd_lo   (rd_pos_reg[2:0]),
        .bit_pos (bit_pos_reg),
        .count   (count_sat),
        .value   (extract_value)
    );

    // Push or read decision and next state
    always_comb begin
        rd_pos_next  = rd_pos_reg;
        wr_pos_next  = wr_pos_reg;
        held_next    = held_reg;
        bit_pos_next = bit_pos_reg;
        last_ff_next = last_ff_reg;
        push_wr      = 1'b0;
        value_next   = 32'd0;
        status_next  = mbru_pkg::ST_OK;
        if (fire) begin
            if (in_func_reg == mbru_pkg::FUNC_PUSH) begin
                if (unstuff_reg && last_ff_reg && (in_data_reg == 8'd0)) begin
                    // stuffed zero after a marker byte is dropped
                    last_ff_next = 1'b0;
                end else if (held_reg >= HW'(BUFFER_BYTES)) begin
                    status_next = mbru_pkg::ST_FULL;
                end else begin
                    push_wr      = 1'b1;
                    wr_pos_next  = wr_pos_reg + PW'(1);
                    held_next    = held_reg + HW'(1);
                    last_ff_next = (in_data_reg == mbru_pkg::MARKER_BYTE);
                end
            end else begin
                if (AW'(count_sat) > avail_now) begin
                    status_next = mbru_pkg::ST_UNDERFLOW;
                end else begin
                    value_next = extract_value;
                    if (!in_peek_reg) begin
                        rd_pos_next  = rd_pos_reg + PW'(advance);
                        held_next    = held_reg - HW'(advance);
                        bit_pos_next = total[2:0];
                    end
                end
            end
        end
    end

    assign avail_next   = {held_next, 3'b000} - AW'(bit_pos_next);
    assign rd_addr_base = aresetn ? rd_pos_next : '0;

    // Byte banks; each is read every cycle at the row holding its next window byte
    for (genvar k = 0; k < mbru_pkg::BANKS; k++) begin : g_bank
        localparam logic [2:0] K = 3'(k);
        logic             bank_we;
        logic [ROW_W-1:0] bank_rd_addr;

        assign bank_we      = push_wr && (wr_pos_reg[2:0] == K);
        assign bank_rd_addr = rd_addr_base[PW-1:3]
                              + ROW_W'((K < rd_addr_base[2:0]) ? 1 : 0);

        mbru_bank #(
            .ROW_W (ROW_W)
        ) u_bank (
            .aclk    (aclk),
            .wr_en   (bank_we),
            .wr_addr (wr_pos_reg[PW-1:3]),
            .wr_data (in_data_reg),
            .rd_addr (bank_rd_addr),
            .rd_data (bank_q[k])
        );
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unstuff_reg  <= 1'b0;
            in_valid_reg <= 1'b0;
            rd_pos_reg   <= '0;
            wr_pos_reg   <= '0;
            held_reg     <= '0;
            bit_pos_reg  <= '0;
            last_ff_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unstuff_reg <= cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            rd_pos_reg  <= rd_pos_next;
            wr_pos_reg  <= wr_pos_next;
            held_reg    <= held_next;
            bit_pos_reg <= bit_pos_next;
            last_ff_reg <= last_ff_next;
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Input word register
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_func_reg  <= s_func;
            in_data_reg  <= s_data_byte;
            in_count_reg <= s_bit_count;
            in_peek_reg  <= s_peek;
        end
    end

    // Result word register
    always_ff @(posedge aclk) begin
        if (fire) begin
            m_value_reg  <= value_next;
            m_status_reg <= status_next;
            m_avail_reg  <= 10'(avail_next);
            m_offset_reg <= bit_pos_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_bits_value     = m_value_reg;
    assign m_status         = m_status_reg;
    assign m_available_bits = m_avail_reg;
    assign m_bit_offset     = m_offset_reg;

endmodule
